// ----- src/nv21_scale_and_bgr_convert_core_macros.svh -----
// Assertion macros for the NV21 scale and BGR convert core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef NV21_SCALE_AND_BGR_CONVERT_CORE_MACROS_SVH
`define NV21_SCALE_AND_BGR_CONVERT_CORE_MACROS_SVH

// Condition must never hold outside reset
`define NVSBC_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("nvsbc: forbidden condition");

// Antecedent implies consequent in the same cycle
`define NVSBC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nvsbc: implication failed");

`endif

// ----- src/nvsbc_pkg.sv -----
// Shared types, constants and helpers for the NV21 scale and BGR convert core.
// No dependencies.
package nvsbc_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 640;
    localparam int unsigned DEF_MAX_HEIGHT = 480;

    localparam int unsigned CFG_W   = 10;   // widest config register
    localparam int unsigned ROW_W   = 9;
    localparam int unsigned COL_W   = 10;
    localparam int unsigned PROD_W  = 20;   // coordinate times size
    localparam int unsigned CALC_W  = 22;   // computed store address
    localparam int unsigned QUEUE_DEPTH = 4;

    // BT.601 coefficients, 16 fractional bits
    localparam logic signed [17:0] COEF_BU = 18'sd116195;
    localparam logic signed [17:0] COEF_GV = 18'sd46792;
    localparam logic signed [17:0] COEF_GU = 18'sd22544;
    localparam logic signed [17:0] COEF_RV = 18'sd91947;

    typedef enum logic [1:0] {
        CFG_SRC_W = 2'd0,
        CFG_SRC_H = 2'd1,
        CFG_TGT_W = 2'd2,
        CFG_TGT_H = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_BAD   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               frame_start;
        logic [7:0]         source_byte;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DSTART,
        BK_DWAIT,
        BK_FETCH,
        BK_PROD,
        BK_SUM,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic busy;
        logic done_fire;
    } back_stat_t;

    // Floor by 2^16 and saturate to 0..255
    function automatic logic [7:0] clamp8(input logic signed [26:0] acc);
        logic [7:0] res;
        if (acc[26])
            res = 8'd0;
        else if (|acc[25:24])
            res = 8'd255;
        else
            res = acc[23:16];
        return res;
    endfunction

endpackage

// ----- src/nvsbc_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module nvsbc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/nvsbc_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient known to fit COL_W bits.
// Depends on nvsbc_pkg.
module nvsbc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nvsbc_pkg::PROD_W-1:0]  num,
    input  logic [nvsbc_pkg::CFG_W-1:0]   den,
    output logic                          busy,
    output logic [nvsbc_pkg::COL_W-1:0]   quot
);

    localparam int unsigned QW = nvsbc_pkg::COL_W;
    localparam int unsigned DW = nvsbc_pkg::CFG_W;
    localparam int unsigned NW = nvsbc_pkg::PROD_W;
    localparam int unsigned CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg;
    logic [QW-1:0] low_reg;
    logic [QW-1:0] quot_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;
    logic          fits;

    // trial subtract of the next partial remainder
    assign trial = {rem_reg, low_reg[QW-1]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num[NW-1:QW];
            low_reg  <= num[QW-1:0];
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
            low_reg  <= {low_reg[QW-2:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// ----- src/nvsbc_front.sv -----
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on nvsbc_pkg.
module nvsbc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [7:0]                    source_byte,
    input  logic                          frame_start,
    input  logic [nvsbc_pkg::ROW_W-1:0]   target_row,
    input  logic [nvsbc_pkg::COL_W-1:0]   target_col,
    input  logic [nvsbc_pkg::CFG_W-1:0]   tgt_w,
    input  logic [nvsbc_pkg::CFG_W-1:0]   tgt_h,
    output logic                          cmd_valid,
    output nvsbc_pkg::cmd_t               cmd,
    input  logic                          cmd_pop
);

    localparam int unsigned QD  = nvsbc_pkg::QUEUE_DEPTH;
    localparam int unsigned QAW = $clog2(QD);

    nvsbc_pkg::cmd_t q_mem [QD];
    logic [QAW-1:0]  wr_ptr_reg;
    logic [QAW-1:0]  rd_ptr_reg;
    logic [QAW:0]    count_reg;
    logic            push;
    nvsbc_pkg::cmd_t new_cmd;

    // classify the incoming transfer
    always_comb
    begin
        new_cmd.frame_start = frame_start;
        new_cmd.source_byte = source_byte;
        new_cmd.row         = target_row;
        new_cmd.col         = target_col;
        if (!opcode)
            new_cmd.kind = nvsbc_pkg::KIND_LOAD;
        else if ({1'b0, target_row} >= tgt_h || target_col >= tgt_w)
            new_cmd.kind = nvsbc_pkg::KIND_BAD;
        else
            new_cmd.kind = nvsbc_pkg::KIND_PIXEL;
    end

    assign in_ready  = count_reg != (QAW+1)'(QD);
    assign push      = in_valid && in_ready;
    assign cmd_valid = count_reg != '0;
    assign cmd       = q_mem[rd_ptr_reg];

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (cmd_pop)
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !cmd_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && cmd_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= new_cmd;
    end

endmodule

// ----- src/nvsbc_back.sv -----
// Back end: frame store loads, coordinate division, store fetches, BT.601 convert.
// Depends on nvsbc_pkg, nvsbc_ram, nvsbc_div.
module nvsbc_back #(
    parameter int unsigned MAX_WIDTH  = nvsbc_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = nvsbc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  nvsbc_pkg::cmd_t               cmd,
    output logic                          cmd_pop,
    input  logic [nvsbc_pkg::CFG_W-1:0]   src_w,
    input  logic [nvsbc_pkg::CFG_W-1:0]   src_h,
    input  logic [nvsbc_pkg::CFG_W-1:0]   tgt_w,
    input  logic [nvsbc_pkg::CFG_W-1:0]   tgt_h,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    blue,
    output logic [7:0]                    green,
    output logic [7:0]                    red,
    output logic                          bad_coordinate,
    output nvsbc_pkg::back_stat_t         stat
);

    localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned PW     = $clog2(DEPTH + 1);
    localparam int unsigned COL_W  = nvsbc_pkg::COL_W;
    localparam int unsigned ROW_W  = nvsbc_pkg::ROW_W;
    localparam int unsigned CALC_W = nvsbc_pkg::CALC_W;
    localparam logic [3:0]  LAST_ISSUE = 4'd8;
    localparam logic [3:0]  FETCH_END  = 4'd10;

    nvsbc_pkg::back_state_t state_reg, state_next;

    logic                cmd_pop_i;
    logic                div_start;
    logic                done_fire;
    logic [PW-1:0]       lp_reg;
    logic [PW-1:0]       ld_ptr;
    logic                ld_fits;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [7:0]          ram_rdata;

    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [1:0]          job_reg;
    logic [COL_W-1:0]    q_reg [4];
    logic [nvsbc_pkg::PROD_W-1:0] prod_reg;
    logic                div_busy;
    logic [COL_W-1:0]    div_quot;
    logic                job_row;
    logic [COL_W-1:0]    t_val;
    logic [COL_W-1:0]    mul_s;
    logic [COL_W-1:0]    div_den;

    logic [3:0]          idx_reg;
    logic [2:0]          mem_sel;
    logic                is_luma;
    logic [COL_W-1:0]    srow, scol, sr, sc;
    logic [10:0]         mul_a, add_b;
    logic [CALC_W-1:0]   calc;
    logic                member_ok, in_store, issue;
    logic                a_v_reg, a_use_reg, r_v_reg, r_use_reg;
    logic [AW-1:0]       a_addr_reg;
    logic [3:0]          a_tag_reg, r_tag_reg;
    logic [7:0]          px;

    logic [7:0]          y_reg;
    logic [9:0]          vsum_reg, usum_reg;
    logic signed [8:0]   v_s, u_s;
    logic signed [26:0]  p_bu_reg, p_gv_reg, p_gu_reg, p_rv_reg;
    logic signed [26:0]  yy;
    logic [7:0]          b_res_reg, g_res_reg, r_res_reg;
    logic                bad_res_reg;
    logic [7:0]          blue_reg, green_reg, red_reg;
    logic                bad_reg, out_valid_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nvsbc_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and strobes
    always_comb
    begin
        state_next = state_reg;
        cmd_pop_i  = 1'b0;
        div_start  = 1'b0;
        done_fire  = 1'b0;
        unique case (state_reg)
            nvsbc_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop_i = 1'b1;
                    unique case (cmd.kind)
                        nvsbc_pkg::KIND_PIXEL: state_next = nvsbc_pkg::BK_MUL;
                        nvsbc_pkg::KIND_BAD:   state_next = nvsbc_pkg::BK_DONE;
                        default:               state_next = nvsbc_pkg::BK_IDLE;
                    endcase
                end
            end
            nvsbc_pkg::BK_MUL:    state_next = nvsbc_pkg::BK_DSTART;
            nvsbc_pkg::BK_DSTART:
            begin
                div_start  = 1'b1;
                state_next = nvsbc_pkg::BK_DWAIT;
            end
            nvsbc_pkg::BK_DWAIT:
            begin
                if (!div_busy)
                    state_next = (job_reg == 2'd3) ? nvsbc_pkg::BK_FETCH : nvsbc_pkg::BK_MUL;
            end
            nvsbc_pkg::BK_FETCH:
            begin
                if (idx_reg == FETCH_END)
                    state_next = nvsbc_pkg::BK_PROD;
            end
            nvsbc_pkg::BK_PROD:   state_next = nvsbc_pkg::BK_SUM;
            nvsbc_pkg::BK_SUM:    state_next = nvsbc_pkg::BK_DONE;
            nvsbc_pkg::BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    done_fire  = 1'b1;
                    state_next = nvsbc_pkg::BK_IDLE;
                end
            end
        endcase
    end

    assign cmd_pop = cmd_pop_i;

    // load pointer and store writes
    assign ld_ptr  = cmd.frame_start ? '0 : lp_reg;
    assign ld_fits = ld_ptr < PW'(DEPTH);
    assign ram_we  = cmd_pop_i && (cmd.kind == nvsbc_pkg::KIND_LOAD) && ld_fits;
    assign ram_addr = ram_we ? AW'(ld_ptr) : a_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lp_reg <= '0;
        else if (cmd_pop_i)
            lp_reg <= ram_we ? PW'(ld_ptr + 1'b1) : ld_ptr;
    end

    nvsbc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.source_byte),
        .rdata (ram_rdata)
    );

    // coordinate scaling: two rows and two columns of the 2x2 block
    assign job_row = !job_reg[1];
    assign t_val   = job_row ? {1'b0, row_reg[ROW_W-1:1], job_reg[0]}
                             : {col_reg[COL_W-1:1], job_reg[0]};
    assign mul_s   = job_row ? src_h : src_w;
    assign div_den = job_row ? tgt_h : tgt_w;

    nvsbc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // fetch address: luma first, then V,U of each block member
    assign is_luma = idx_reg == 4'd0;
    assign mem_sel = 3'(idx_reg - 4'd1);
    assign srow    = row_reg[0] ? q_reg[1] : q_reg[0];
    assign scol    = col_reg[0] ? q_reg[3] : q_reg[2];
    assign sr      = mem_sel[2] ? q_reg[1] : q_reg[0];
    assign sc      = mem_sel[1] ? q_reg[3] : q_reg[2];
    assign mul_a   = is_luma ? 11'(srow) : 11'(src_h) + 11'(sr[COL_W-1:1]);
    assign add_b   = is_luma ? 11'(scol) : 11'({sc[COL_W-1:1], 1'b0}) + 11'(mem_sel[0]);
    assign calc    = CALC_W'(mul_a) * CALC_W'(src_w) + CALC_W'(add_b);
    assign member_ok = is_luma ||
        (({1'b0, row_reg[ROW_W-1:1], mem_sel[2]} < tgt_h) &&
         ({col_reg[COL_W-1:1], mem_sel[1]} < tgt_w));
    assign in_store = 32'(calc) < 32'(DEPTH);
    assign issue    = (state_reg == nvsbc_pkg::BK_FETCH) && (idx_reg <= LAST_ISSUE);
    assign px       = r_use_reg ? ram_rdata : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            r_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= issue;
            r_v_reg <= a_v_reg;
        end
    end

    // colour conversion operands
    assign v_s = $signed({1'b0, vsum_reg[9:2]}) - 9'sd128;
    assign u_s = $signed({1'b0, usum_reg[9:2]}) - 9'sd128;
    assign yy  = $signed({3'b000, y_reg, 16'h0000});

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop_i)
        begin
            row_reg     <= cmd.row;
            col_reg     <= cmd.col;
            job_reg     <= 2'd0;
            idx_reg     <= 4'd0;
            vsum_reg    <= '0;
            usum_reg    <= '0;
            b_res_reg   <= 8'd0;
            g_res_reg   <= 8'd0;
            r_res_reg   <= 8'd0;
            bad_res_reg <= cmd.kind == nvsbc_pkg::KIND_BAD;
        end
        if (state_reg == nvsbc_pkg::BK_MUL)
            prod_reg <= t_val * mul_s;
        if (state_reg == nvsbc_pkg::BK_DWAIT && !div_busy)
        begin
            q_reg[job_reg] <= div_quot;
            job_reg        <= job_reg + 1'b1;
        end
        if (state_reg == nvsbc_pkg::BK_FETCH)
            idx_reg <= idx_reg + 1'b1;
        a_addr_reg <= AW'(calc);
        a_use_reg  <= member_ok && in_store;
        a_tag_reg  <= idx_reg;
        r_use_reg  <= a_use_reg;
        r_tag_reg  <= a_tag_reg;
        // accumulate returned store bytes
        if (r_v_reg)
        begin
            if (r_tag_reg == 4'd0)
                y_reg <= px;
            else if (r_tag_reg[0])
                vsum_reg <= vsum_reg + 10'(px);
            else
                usum_reg <= usum_reg + 10'(px);
        end
        if (state_reg == nvsbc_pkg::BK_PROD)
        begin
            p_bu_reg <= nvsbc_pkg::COEF_BU * u_s;
            p_gv_reg <= nvsbc_pkg::COEF_GV * v_s;
            p_gu_reg <= nvsbc_pkg::COEF_GU * u_s;
            p_rv_reg <= nvsbc_pkg::COEF_RV * v_s;
        end
        if (state_reg == nvsbc_pkg::BK_SUM)
        begin
            b_res_reg <= nvsbc_pkg::clamp8(yy + p_bu_reg);
            g_res_reg <= nvsbc_pkg::clamp8(yy - p_gv_reg - p_gu_reg);
            r_res_reg <= nvsbc_pkg::clamp8(yy + p_rv_reg);
        end
        if (done_fire)
        begin
            blue_reg  <= b_res_reg;
            green_reg <= g_res_reg;
            red_reg   <= r_res_reg;
            bad_reg   <= bad_res_reg;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid      = out_valid_reg;
    assign blue           = blue_reg;
    assign green          = green_reg;
    assign red            = red_reg;
    assign bad_coordinate = bad_reg;
    assign stat.busy      = state_reg != nvsbc_pkg::BK_IDLE;
    assign stat.done_fire = done_fire;

endmodule

// ----- src/nv21_scale_and_bgr_convert_core.sv -----
// Top level: config registers, front end queue and back end.
// Depends on nvsbc_pkg, nvsbc_front, nvsbc_back and the assertion macro header.
//
// Channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// in       | in_valid / in_ready    | opcode, source_byte, frame_start, target_row/col
// out      | out_valid / out_ready  | blue, green, red, bad_coordinate
// cfg      | cfg_write              | cfg_index, cfg_data
//
// A load is written to the frame store as it is popped (one frame store write port).
// A pixel request runs four serial 10-step coordinate divisions, nine store reads
// through the single RAM port and two convert steps (BK_PROD, BK_SUM).
// A request with bad coordinates goes straight from idle to the done state.
// Reset is asynchronous active low; the frame store holds garbage until loaded.
// A four-entry queue keeps accepting transfers while the back end or output stalls, until it is full.
`include "nv21_scale_and_bgr_convert_core_macros.svh"

module nv21_scale_and_bgr_convert_core #(
    parameter int unsigned MAX_WIDTH  = nvsbc_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = nvsbc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [nvsbc_pkg::CFG_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [7:0]                    source_byte,
    input  logic                          frame_start,
    input  logic [nvsbc_pkg::ROW_W-1:0]   target_row,
    input  logic [nvsbc_pkg::COL_W-1:0]   target_col,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    blue,
    output logic [7:0]                    green,
    output logic [7:0]                    red,
    output logic                          bad_coordinate
);

    localparam int unsigned CW = nvsbc_pkg::CFG_W;

    logic [9:0]            src_w_reg;
    logic [8:0]            src_h_reg;
    logic [9:0]            tgt_w_reg;
    logic [8:0]            tgt_h_reg;
    logic                  cmd_valid;
    logic                  cmd_pop;
    nvsbc_pkg::cmd_t       cmd;
    nvsbc_pkg::back_stat_t stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= 10'd640;
            src_h_reg <= 9'd480;
            tgt_w_reg <= 10'd640;
            tgt_h_reg <= 9'd480;
        end
        else if (cfg_write)
        begin
            unique case (nvsbc_pkg::cfg_index_t'(cfg_index))
                nvsbc_pkg::CFG_SRC_W: src_w_reg <= cfg_data[9:0];
                nvsbc_pkg::CFG_SRC_H: src_h_reg <= cfg_data[8:0];
                nvsbc_pkg::CFG_TGT_W: tgt_w_reg <= cfg_data[9:0];
                nvsbc_pkg::CFG_TGT_H: tgt_h_reg <= cfg_data[8:0];
            endcase
        end
    end

    nvsbc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .source_byte (source_byte),
        .frame_start (frame_start),
        .target_row  (target_row),
        .target_col  (target_col),
        .tgt_w       (tgt_w_reg),
        .tgt_h       (CW'(tgt_h_reg)),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    nvsbc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .src_w          (src_w_reg),
        .src_h          (CW'(src_h_reg)),
        .tgt_w          (tgt_w_reg),
        .tgt_h          (CW'(tgt_h_reg)),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .bad_coordinate (bad_coordinate),
        .stat           (stat)
    );

    // checks
    `NVSBC_ASSERT_IMPL(a_bad_zero, out_valid && bad_coordinate, (blue | green | red) == 8'd0)
    `NVSBC_ASSERT_IMPL(a_out_source, $rose(out_valid), $past(stat.done_fire))
    `NVSBC_ASSERT_NEVER(a_done_busy, stat.done_fire && !stat.busy)

endmodule
